// ----- sv/bba_pkg.sv -----
`timescale 1ns / 1ps

package bba_pkg;

    // map geometry
    localparam int NUM_BLOCKS = 65536;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);

    // field widths
    localparam int BLK_W      = 16;
    localparam int CNT_W      = 17;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0] NUM_BLOCKS_C = CNT_W'(NUM_BLOCKS);

    // request types
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FORMAT = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FREED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'd1;

endpackage

// ----- sv/bba_ram.sv -----
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/bitmap_block_allocator.sv -----
`timescale 1ns / 1ps
// allocate: scans the map from word 0, over at most 2048 map words, reading
//   one 32-bit map word per cycle through the single read port of the map ram
// free and read: ram read, read-modify-write, result; out of range goes straight to result
// format: one map word written per cycle over the whole map; full map goes straight to result
// one request in flight; next request taken once the result register is loaded
// reset: a clearing pass zeroes the map, no request accepted meanwhile

module bitmap_block_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bba_pkg::CNT_W-1:0]        cfg_data,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bba_pkg::IN_DATA_W-1:0]    s_tdata,   // [15:0] block_number
    input  logic [bba_pkg::REQ_W-1:0]        s_tuser,   // [1:0] req_type
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bba_pkg::OUT_DATA_W-1:0]   m_tdata,   // [15:0] result_block, [16] bit_value,
                                                        // [33:17] free_left, [39:34] zero
    output logic [bba_pkg::STAT_W-1:0]       m_tuser    // [1:0] status
);

    import bba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_SCAN  = 5'b00100,
        S_RMW   = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [CNT_W-1:0]    fmt_lim_reg, fmt_lim_next;
    logic                fmt_resp_reg, fmt_resp_next;
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    reserved_reg, reserved_next;
    logic [BLK_W-1:0]    res_block_reg, res_block_next;
    logic                res_bit_reg, res_bit_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [BLK_W-1:0]    out_block_reg, out_block_next;
    logic                out_bit_reg, out_bit_next;
    logic [CNT_W-1:0]    out_free_reg, out_free_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;

    logic                   accept;
    logic [CNT_W-1:0]       eff_total;
    logic [CNT_W-1:0]       base;
    logic [CNT_W-1:0]       fmt_diff;
    logic [WORD_BITS-1:0]   fmt_word;
    logic [WORD_BITS-1:0]   inv_word;
    logic [BIT_W-1:0]       first_zero;
    logic [CNT_W-1:0]       found_pos;
    logic                   cur_bit;
    logic [WORD_BITS-1:0]   bit_mask;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // blocks beyond the map are never managed
    assign eff_total = (total_reg > NUM_BLOCKS_C) ? NUM_BLOCKS_C : total_reg;

    // first block number of the current map word
    assign base = {{(CNT_W - ADDR_W - BIT_W){1'b0}}, addr_reg, {BIT_W{1'b0}}};

    // format word: bits below the reserved limit are set
    assign fmt_diff = fmt_lim_reg - base;
    always_comb
    begin
        if (fmt_lim_reg <= base)
        begin
            fmt_word = '0;
        end
        else if (fmt_diff >= CNT_W'(WORD_BITS))
        begin
            fmt_word = '1;
        end
        else
        begin
            fmt_word = ~({WORD_BITS{1'b1}} << fmt_diff[BIT_W-1:0]);
        end
    end

    // lowest clear bit of the word being scanned
    assign inv_word = ~ram_rdata;
    always_comb
    begin
        first_zero = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (inv_word[i])
            begin
                first_zero = BIT_W'(i);
            end
        end
    end
    assign found_pos = base + CNT_W'(first_zero);

    // single bit of a free or read request
    assign bit_mask = WORD_BITS'(1) << blk_reg[BIT_W-1:0];
    assign cur_bit  = ram_rdata[blk_reg[BIT_W-1:0]];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        blk_next        = blk_reg;
        req_next        = req_reg;
        fmt_lim_next    = fmt_lim_reg;
        fmt_resp_next   = fmt_resp_reg;
        free_count_next = free_count_reg;
        total_next      = total_reg;
        reserved_next   = reserved_reg;
        res_block_next  = res_block_reg;
        res_bit_next    = res_bit_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_block_next  = out_block_reg;
        out_bit_next    = out_bit_reg;
        out_free_next   = out_free_reg;
        out_status_next = out_status_reg;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_raddr = addr_reg + ADDR_W'(1);

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOTAL:    total_next    = cfg_data;
                REG_RESERVED: reserved_next = cfg_data;
                default:      ;
            endcase
        end

        // result register drains
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tuser == REQ_ALLOC)
                begin
                    ram_raddr = '0;
                end
                else
                begin
                    ram_raddr = s_tdata[BLK_W-1:BIT_W];
                end
                if (accept)
                begin
                    blk_next = s_tdata[BLK_W-1:0];
                    req_next = s_tuser;
                    unique case (s_tuser) inside
                        REQ_ALLOC:
                        begin
                            if (free_count_reg == '0)
                            begin
                                res_block_next  = '0;
                                res_bit_next    = 1'b0;
                                res_status_next = ST_FULL;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                addr_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        REQ_FREE, REQ_READ:
                        begin
                            if (CNT_W'(s_tdata[BLK_W-1:0]) >= eff_total)
                            begin
                                res_block_next  = s_tdata[BLK_W-1:0];
                                res_bit_next    = 1'b0;
                                res_status_next = ST_RANGE;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                addr_next  = s_tdata[BLK_W-1:BIT_W];
                                state_next = S_RMW;
                            end
                        end
                        default:
                        begin
                            fmt_lim_next  = (reserved_reg > eff_total) ? eff_total
                                                                       : reserved_reg;
                            fmt_resp_next = 1'b1;
                            addr_next     = '0;
                            state_next    = S_CLEAR;
                        end
                    endcase
                end
            end

            // sweep the whole map, one word a cycle
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = fmt_word;
                if (addr_reg == LAST_WORD)
                begin
                    if (fmt_resp_reg)
                    begin
                        free_count_next = eff_total - fmt_lim_reg;
                        res_block_next  = '0;
                        res_bit_next    = 1'b0;
                        res_status_next = ST_OK;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            // first fit: read data of word addr_reg arrives, next word is requested
            S_SCAN:
            begin
                if (base >= eff_total)
                begin
                    res_block_next  = '0;
                    res_bit_next    = 1'b0;
                    res_status_next = ST_FULL;
                    state_next      = S_RESP;
                end
                else if (inv_word != '0)
                begin
                    if (found_pos >= eff_total)
                    begin
                        res_block_next  = '0;
                        res_bit_next    = 1'b0;
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = ram_rdata | (WORD_BITS'(1) << first_zero);
                        free_count_next = free_count_reg - CNT_W'(1);
                        res_block_next  = found_pos[BLK_W-1:0];
                        res_bit_next    = 1'b1;
                        res_status_next = ST_OK;
                    end
                    state_next = S_RESP;
                end
                else if (addr_reg == LAST_WORD)
                begin
                    res_block_next  = '0;
                    res_bit_next    = 1'b0;
                    res_status_next = ST_FULL;
                    state_next      = S_RESP;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            // single-bit read or clear
            S_RMW:
            begin
                res_block_next = blk_reg;
                if (req_reg == REQ_FREE)
                begin
                    res_bit_next = 1'b0;
                    if (!cur_bit)
                    begin
                        res_status_next = ST_FREED;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = ram_rdata & ~bit_mask;
                        res_status_next = ST_OK;
                        if (free_count_reg != '1)
                        begin
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    res_bit_next    = cur_bit;
                    res_status_next = ST_OK;
                end
                state_next = S_RESP;
            end

            // hand over to the result register once it is free
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_block_next  = res_block_reg;
                    out_bit_next    = res_bit_reg;
                    out_free_next   = free_count_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            addr_reg       <= '0;
            fmt_lim_reg    <= '0;
            fmt_resp_reg   <= 1'b0;
            free_count_reg <= NUM_BLOCKS_C;
            total_reg      <= NUM_BLOCKS_C;
            reserved_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            fmt_lim_reg    <= fmt_lim_next;
            fmt_resp_reg   <= fmt_resp_next;
            free_count_reg <= free_count_next;
            total_reg      <= total_next;
            reserved_reg   <= reserved_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        blk_reg        <= blk_next;
        req_reg        <= req_next;
        res_block_reg  <= res_block_next;
        res_bit_reg    <= res_bit_next;
        res_status_reg <= res_status_next;
        out_block_reg  <= out_block_next;
        out_bit_reg    <= out_bit_next;
        out_free_reg   <= out_free_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - BLK_W - 1 - CNT_W){1'b0}},
                       out_free_reg, out_bit_reg, out_block_reg};
    assign m_tuser  = out_status_reg;

    // map is written only by the sweep, the scan or the bit update
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_SCAN || state_reg == S_RMW))
        else $error("map written outside an update state");

    // a taken request closes the input until its result is out
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request accepted while busy");

    // results are loaded only from the result state
    a_load_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_RESP))
        else $error("result loaded outside the result state");

    // a full map answers block zero, bit clear
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_status_reg == ST_FULL) |-> (out_block_reg == '0 && !out_bit_reg))
        else $error("full map result carries a block");

    // an allocation takes exactly one free block
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && ram_we) |=> (free_count_reg == $past(free_count_reg) - 17'd1))
        else $error("free count not decremented on allocate");

endmodule

// ----- dv/bitmap_block_allocator_test.sv -----
`timescale 1ns / 1ps

module bitmap_block_allocator_test;

    import bba_pkg::*;

    // one allocator answer, as carried by the result stream
    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic              used;
        logic [CNT_W-1:0]  left;
        logic [STAT_W-1:0] st;
    } alloc_answer_t;

    // one line of the directed plan: a request or a register write
    typedef struct packed {
        logic              is_cfg;
        logic [REQ_W-1:0]  code;
        logic [CNT_W-1:0]  arg;
        logic              known;
        alloc_answer_t     answer;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CNT_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    // typed answer travelling beside a directed request
    logic                  row_known;
    alloc_answer_t         row_answer;

    // shadow copy of the allocator
    logic [WORD_BITS-1:0]  shadow_map [MAP_WORDS];
    logic [CNT_W-1:0]      shadow_free;
    logic [CNT_W-1:0]      shadow_total;
    logic [CNT_W-1:0]      shadow_reserved;

    alloc_answer_t         answer_q [$];
    plan_row_t             plan [$];
    int                    err_cnt;
    logic                  quiet_phase;
    alloc_answer_t         got_answer;
    alloc_answer_t         want_answer;
    alloc_answer_t         new_answer;

    bitmap_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // usable block count
    function automatic int usable_blocks();
        if (int'(shadow_total) > NUM_BLOCKS)
            return NUM_BLOCKS;
        return int'(shadow_total);
    endfunction

    // apply one request to the shadow state and return its answer
    function automatic alloc_answer_t predict_answer(input logic [REQ_W-1:0] req,
                                                     input logic [BLK_W-1:0] blk);
        alloc_answer_t ans;
        int tot;
        int base;
        int r;
        logic [WORD_BITS-1:0] clear_bits;
        tot = usable_blocks();
        ans = '{blk: '0, used: 1'b0, left: '0, st: ST_OK};
        case (req)
            REQ_ALLOC:
            begin
                ans.st = ST_FULL;
                if (shadow_free != 0)
                begin
                    for (int w = 0; w < MAP_WORDS; w++)
                    begin
                        base = w * WORD_BITS;
                        if (base >= tot)
                            break;
                        clear_bits = ~shadow_map[w];
                        if (clear_bits == '0)
                            continue;
                        for (int p = 0; p < WORD_BITS; p++)
                        begin
                            if (clear_bits[p])
                            begin
                                base = base + p;
                                break;
                            end
                        end
                        if (base >= tot)
                            break;
                        shadow_map[w][base % WORD_BITS] = 1'b1;
                        shadow_free = shadow_free - CNT_W'(1);
                        ans.blk  = BLK_W'(base);
                        ans.used = 1'b1;
                        ans.st   = ST_OK;
                        break;
                    end
                end
            end
            REQ_FREE:
            begin
                ans.blk = blk;
                if (int'(blk) >= tot)
                    ans.st = ST_RANGE;
                else if (!shadow_map[blk / WORD_BITS][blk % WORD_BITS])
                    ans.st = ST_FREED;
                else
                begin
                    shadow_map[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
                    // counter saturates at all ones
                    if (shadow_free != '1)
                        shadow_free = shadow_free + CNT_W'(1);
                end
            end
            REQ_READ:
            begin
                ans.blk = blk;
                if (int'(blk) >= tot)
                    ans.st = ST_RANGE;
                else
                    ans.used = shadow_map[blk / WORD_BITS][blk % WORD_BITS];
            end
            default:
            begin
                r = int'(shadow_reserved);
                if (r > tot)
                    r = tot;
                foreach (shadow_map[w])
                    shadow_map[w] = '0;
                for (int i = 0; i < r; i++)
                    shadow_map[i / WORD_BITS][i % WORD_BITS] = 1'b1;
                shadow_free = CNT_W'(tot - r);
            end
        endcase
        ans.left = shadow_free;
        return ans;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result checking and request prediction, sampled at the clock edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_answer.blk  = m_tdata[BLK_W-1:0];
            got_answer.used = m_tdata[BLK_W];
            got_answer.left = m_tdata[BLK_W+1 +: CNT_W];
            got_answer.st   = m_tuser;
            if (answer_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         got_answer);
            end
            else
            begin
                want_answer = answer_q.pop_front();
                check_field("result_block", want_answer.blk, got_answer.blk);
                check_field("bit_value", want_answer.used, got_answer.used);
                check_field("free_left", want_answer.left, got_answer.left);
                check_field("status", want_answer.st, got_answer.st);
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            new_answer = predict_answer(s_tuser, s_tdata[BLK_W-1:0]);
            if (row_known)
                new_answer = row_answer;
            answer_q.push_back(new_answer);
        end
    end

    // result sink with random backpressure
    initial
    begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // offer one request and hold it until taken
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [BLK_W-1:0] blk,
                            input logic known, input alloc_answer_t answer);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= blk;
        s_tuser    <= req;
        row_known  <= known;
        row_answer <= answer;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering and wait for every outstanding answer
    task automatic finish_pending();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_TOTAL)
            shadow_total = val;
        else
            shadow_reserved = val;
    endtask

    function automatic plan_row_t req_row(input logic [REQ_W-1:0] req, input int blk);
        return '{is_cfg: 1'b0, code: req, arg: CNT_W'(blk), known: 1'b0, answer: '0};
    endfunction

    function automatic plan_row_t req_known(input logic [REQ_W-1:0] req, input int blk,
                                            input int rblk, input logic used,
                                            input int left, input logic [STAT_W-1:0] st);
        plan_row_t row;
        row = req_row(req, blk);
        row.known  = 1'b1;
        row.answer = '{blk: BLK_W'(rblk), used: used, left: CNT_W'(left), st: st};
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        return '{is_cfg: 1'b1, code: REQ_W'(idx), arg: CNT_W'(val), known: 1'b0,
                 answer: '0};
    endfunction

    // run time limit
    initial
    begin
        #400_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        int tot;
        int resv;
        int pick;
        int blk_i;
        int sel;
        logic [REQ_W-1:0] req;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        row_known   = 1'b0;
        row_answer  = '0;
        quiet_phase = 1'b0;
        err_cnt     = 0;

        // state after reset
        foreach (shadow_map[w])
            shadow_map[w] = '0;
        shadow_total    = NUM_BLOCKS_C;
        shadow_reserved = '0;
        shadow_free     = NUM_BLOCKS_C;

        // directed plan
        plan.push_back(req_known(REQ_READ, 0, 0, 1'b0, 65536, ST_OK));
        plan.push_back(req_known(REQ_READ, 65535, 65535, 1'b0, 65536, ST_OK));
        plan.push_back(req_known(REQ_FREE, 5, 5, 1'b0, 65536, ST_FREED));
        plan.push_back(req_known(REQ_ALLOC, 65535, 0, 1'b1, 65535, ST_OK));
        plan.push_back(req_known(REQ_ALLOC, 0, 1, 1'b1, 65534, ST_OK));
        plan.push_back(req_known(REQ_READ, 1, 1, 1'b1, 65534, ST_OK));
        plan.push_back(req_known(REQ_FREE, 0, 0, 1'b0, 65535, ST_OK));
        plan.push_back(req_row(REQ_ALLOC, 16'h1234));
        // small map with reserved head
        plan.push_back(reg_row(REG_TOTAL, 40));
        plan.push_back(reg_row(REG_RESERVED, 35));
        plan.push_back(req_known(REQ_FORMAT, 65535, 0, 1'b0, 5, ST_OK));
        for (int i = 0; i < 5; i++)
            plan.push_back(req_row(REQ_ALLOC, 16'hA5A5));
        // map full, out of range
        plan.push_back(req_known(REQ_ALLOC, 0, 0, 1'b0, 0, ST_FULL));
        plan.push_back(req_known(REQ_FREE, 40, 40, 1'b0, 0, ST_RANGE));
        plan.push_back(req_known(REQ_READ, 65535, 65535, 1'b0, 0, ST_RANGE));
        plan.push_back(req_row(REQ_FREE, 39));
        // count nonzero but no clear bit below the total
        plan.push_back(reg_row(REG_TOTAL, 1));
        plan.push_back(req_known(REQ_ALLOC, 0, 0, 1'b0, 1, ST_FULL));
        // whole map reserved
        plan.push_back(reg_row(REG_TOTAL, 65536));
        plan.push_back(reg_row(REG_RESERVED, 65536));
        plan.push_back(req_known(REQ_FORMAT, 0, 0, 1'b0, 0, ST_OK));
        plan.push_back(req_known(REQ_ALLOC, 0, 0, 1'b0, 0, ST_FULL));
        plan.push_back(req_known(REQ_READ, 65535, 65535, 1'b1, 0, ST_OK));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                finish_pending();
                set_register(plan[i].code[CFG_IDX_W-1:0], plan[i].arg);
            end
            else
                send_req(plan[i].code, plan[i].arg[BLK_W-1:0], plan[i].known,
                         plan[i].answer);
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < 22; phase++)
        begin
            finish_pending();
            quiet_phase = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // large map, nearly all reserved so the scan runs far
                tot  = $urandom_range(0, 1) ? 65536 : $urandom_range(32768, 65536);
                resv = tot - $urandom_range(0, 40);
            end
            else
            begin
                tot  = $urandom_range(1, 600);
                resv = $urandom_range(0, tot + 40);
            end
            sel = $urandom_range(0, 5);
            if (sel != 1)
                set_register(REG_TOTAL, CNT_W'(tot));
            if (sel != 0)
                set_register(REG_RESERVED, CNT_W'(resv));
            // most phases start from a fresh format
            if ($urandom_range(0, 4) != 0)
                send_req(REQ_FORMAT, BLK_W'($urandom), 1'b0, '0);
            for (int n = 0; n < 50; n++)
            begin
                tot  = usable_blocks();
                pick = $urandom_range(0, 99);
                if (pick < 38)
                    req = REQ_ALLOC;
                else if (pick < 72)
                    req = REQ_FREE;
                else if (pick < 97)
                    req = REQ_READ;
                else
                    req = REQ_FORMAT;
                pick = $urandom_range(0, 99);
                if (tot > 0 && pick < 70)
                    blk_i = $urandom_range(0, tot - 1);
                else if (pick < 85)
                begin
                    // around the end of the valid range
                    blk_i = tot - 1 + $urandom_range(0, 3);
                    if (blk_i > 65535)
                        blk_i = 65535;
                    if (blk_i < 0)
                        blk_i = 0;
                end
                else
                    blk_i = $urandom_range(0, 65535);
                send_req(req, BLK_W'(blk_i), 1'b0, '0);
            end
        end

        finish_pending();
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bitmap_block_allocator.sv
dv/bitmap_block_allocator_test.sv
